[hw/rtl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and codes for the snooping coherence controller: line states,
// snooped bus messages, cache actions and protocol selections.
// ----------------------------------------------------------------------------
package scc_pkg;

	typedef enum logic [3:0] {
		ST_I  = 4'd0,
		ST_S  = 4'd1,
		ST_E  = 4'd2,
		ST_O  = 4'd3,
		ST_F  = 4'd4,
		ST_M  = 4'd5,
		ST_IS = 4'd6,
		ST_IM = 4'd7,
		ST_SM = 4'd8,
		ST_OM = 4'd9
	} line_state_t;

	typedef enum logic [1:0] {
		REQ_BUSRD  = 2'd0,
		REQ_BUSWR  = 2'd1,
		REQ_DATA   = 2'd2,
		REQ_SHARED = 2'd3
	} bus_req_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_INV  = 2'd1,
		ACT_RECV = 2'd2
	} cache_act_t;

	typedef enum logic [2:0] {
		SCH_MI    = 3'd0,
		SCH_MSI   = 3'd1,
		SCH_MESI  = 3'd2,
		SCH_MOESI = 3'd3,
		SCH_MESIF = 3'd4
	} scheme_t;

	localparam logic OP_ACCESS = 1'b0;
	localparam logic OP_SNOOP  = 1'b1;

endpackage

[hw/rtl/snoop_coherence_controller_core.sv]
// ----------------------------------------------------------------------------
// snoop_coherence_controller_core
// Per-line coherence transition logic for a snooping bus cache; MI, MSI,
// MESI, MOESI or MESIF selected by the scheme register.
// ----------------------------------------------------------------------------
//
// Channel     Handshake           Payload
// ---------   -----------------   ---------------------------------------------
// request     start / busy        op, is_read, bus_request, current_state,
//                                 line_address, proc_id
// result      done (strobe)       next_state, perm_avail, action, issue_*,
//                                 bus_address, bus_proc, error
// config      cfg_we              cfg_wdata (scheme)
//
// One transaction per cycle; busy stays low. An accepted transaction passes one
// input register, the transition logic and one result register, which drives
// done. Reset clears the valid bits and selects MI.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module snoop_coherence_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic        is_read,
	input  logic [1:0]  bus_request,
	input  logic [3:0]  current_state,
	input  logic [63:0] line_address,
	input  logic [7:0]  proc_id,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_wdata,
	output logic        done,
	output logic [3:0]  next_state,
	output logic        perm_avail,
	output logic [1:0]  action,
	output logic        issue_busrd,
	output logic        issue_buswr,
	output logic        issue_data,
	output logic        issue_shared,
	output logic [63:0] bus_address,
	output logic [7:0]  bus_proc,
	output logic        error
);

	logic [2:0]  scheme_q;

	logic        vld_s1;
	logic        op_s1;
	logic        rd_s1;
	logic [1:0]  req_s1;
	logic [3:0]  st_s1;
	logic [63:0] addr_s1;
	logic [7:0]  proc_s1;

	logic        vld_s2;
	logic [3:0]  nxt_s2;
	logic        perm_s2;
	logic [1:0]  act_s2;
	logic        brd_s2;
	logic        bwr_s2;
	logic        bdata_s2;
	logic        bshr_s2;
	logic [63:0] addr_s2;
	logic [7:0]  proc_s2;
	logic        err_s2;

	logic        is_mi;
	logic        f_excl;
	logic        f_owned;
	logic        f_fwd;
	logic [3:0]  nxt;
	logic        perm;
	logic [1:0]  act;
	logic        brd;
	logic        bwr;
	logic        bdata;
	logic        bshr;
	logic        err;
	logic        any_msg;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scheme_q <= scc_pkg::SCH_MI;
		end else if (cfg_we) begin
			scheme_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_s1   <= op;
			rd_s1   <= is_read;
			req_s1  <= bus_request;
			st_s1   <= current_state;
			addr_s1 <= line_address;
			proc_s1 <= proc_id;
		end
	end

	// undefined scheme codes fall back to MI
	always_comb begin
		is_mi   = !(scheme_q inside {scc_pkg::SCH_MSI, scc_pkg::SCH_MESI,
			scc_pkg::SCH_MOESI, scc_pkg::SCH_MESIF});
		f_excl  = scheme_q inside {scc_pkg::SCH_MESI, scc_pkg::SCH_MOESI,
			scc_pkg::SCH_MESIF};
		f_owned = (scheme_q == scc_pkg::SCH_MOESI);
		f_fwd   = (scheme_q == scc_pkg::SCH_MESIF);
	end

	always_comb begin
		nxt   = scc_pkg::ST_I;
		perm  = 1'b0;
		act   = scc_pkg::ACT_NONE;
		brd   = 1'b0;
		bwr   = 1'b0;
		bdata = 1'b0;
		bshr  = 1'b0;
		err   = 1'b0;
		if (op_s1 == scc_pkg::OP_ACCESS) begin
			if (is_mi) begin
				case (st_s1)
					scc_pkg::ST_I: begin
						bwr = 1'b1;
						nxt = scc_pkg::ST_IM;
					end
					scc_pkg::ST_M: begin
						perm = 1'b1;
						nxt  = scc_pkg::ST_M;
					end
					scc_pkg::ST_IM: nxt = scc_pkg::ST_IM;
					default: err = 1'b1;
				endcase
			end else begin
				case (st_s1)
					scc_pkg::ST_I: begin
						brd = rd_s1;
						bwr = !rd_s1;
						nxt = rd_s1 ? scc_pkg::ST_IS : scc_pkg::ST_IM;
					end
					scc_pkg::ST_S, scc_pkg::ST_F: begin
						perm = rd_s1;
						bwr  = !rd_s1;
						nxt  = rd_s1 ? st_s1 : scc_pkg::ST_SM;
					end
					scc_pkg::ST_E: begin
						perm = 1'b1;
						nxt  = rd_s1 ? scc_pkg::ST_E : scc_pkg::ST_M;
					end
					scc_pkg::ST_M: begin
						perm = 1'b1;
						nxt  = scc_pkg::ST_M;
					end
					scc_pkg::ST_O: begin
						perm = rd_s1;
						bwr  = !rd_s1;
						nxt  = rd_s1 ? scc_pkg::ST_O : scc_pkg::ST_OM;
					end
					scc_pkg::ST_IS, scc_pkg::ST_IM, scc_pkg::ST_SM, scc_pkg::ST_OM:
						nxt = st_s1;
					default: err = 1'b1;
				endcase
			end
		end else if (is_mi) begin
			case (st_s1)
				scc_pkg::ST_I: nxt = scc_pkg::ST_I;
				scc_pkg::ST_M: begin
					bdata = 1'b1;
					act   = scc_pkg::ACT_INV;
				end
				scc_pkg::ST_IM: begin
					if (req_s1 inside {scc_pkg::REQ_DATA, scc_pkg::REQ_SHARED}) begin
						act = scc_pkg::ACT_RECV;
						nxt = scc_pkg::ST_M;
					end else begin
						nxt = scc_pkg::ST_IM;
					end
				end
				default: err = 1'b1;
			endcase
		end else if (st_s1 > scc_pkg::ST_OM) begin
			err = 1'b1;
		end else if (req_s1 inside {scc_pkg::REQ_DATA, scc_pkg::REQ_SHARED}) begin
			// fill responses; anything outside a pending state is unexpected
			case (st_s1)
				scc_pkg::ST_IS: begin
					act = scc_pkg::ACT_RECV;
					if (req_s1 == scc_pkg::REQ_DATA)
						nxt = f_excl ? scc_pkg::ST_E : scc_pkg::ST_S;
					else
						nxt = f_fwd ? scc_pkg::ST_F : scc_pkg::ST_S;
				end
				scc_pkg::ST_IM, scc_pkg::ST_SM, scc_pkg::ST_OM: begin
					act = scc_pkg::ACT_RECV;
					nxt = scc_pkg::ST_M;
				end
				default: begin
					nxt = st_s1;
					err = 1'b1;
				end
			endcase
		end else begin
			case (st_s1)
				scc_pkg::ST_I: nxt = scc_pkg::ST_I;
				scc_pkg::ST_S: begin
					bshr = (req_s1 == scc_pkg::REQ_BUSRD);
					nxt  = bshr ? scc_pkg::ST_S : scc_pkg::ST_I;
					act  = bshr ? scc_pkg::ACT_NONE : scc_pkg::ACT_INV;
				end
				scc_pkg::ST_F: begin
					bshr  = (req_s1 == scc_pkg::REQ_BUSRD);
					bdata = bshr;
					nxt   = bshr ? scc_pkg::ST_S : scc_pkg::ST_I;
					act   = bshr ? scc_pkg::ACT_NONE : scc_pkg::ACT_INV;
				end
				scc_pkg::ST_E, scc_pkg::ST_M, scc_pkg::ST_O: begin
					bdata = 1'b1;
					if (req_s1 == scc_pkg::REQ_BUSRD) begin
						bshr = 1'b1;
						if (st_s1 == scc_pkg::ST_E)
							nxt = scc_pkg::ST_S;
						else if (st_s1 == scc_pkg::ST_O)
							nxt = scc_pkg::ST_O;
						else
							nxt = f_owned ? scc_pkg::ST_O : scc_pkg::ST_S;
					end else begin
						act = scc_pkg::ACT_INV;
					end
				end
				default: nxt = st_s1;
			endcase
		end
	end

	assign any_msg = brd | bwr | bdata | bshr;

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			nxt_s2   <= nxt;
			perm_s2  <= perm;
			act_s2   <= act;
			brd_s2   <= brd;
			bwr_s2   <= bwr;
			bdata_s2 <= bdata;
			bshr_s2  <= bshr;
			addr_s2  <= any_msg ? addr_s1 : 64'd0;
			proc_s2  <= any_msg ? proc_s1 : 8'd0;
			err_s2   <= err;
		end
	end

	assign done         = vld_s2;
	assign next_state   = nxt_s2;
	assign perm_avail   = perm_s2;
	assign action       = act_s2;
	assign issue_busrd  = brd_s2;
	assign issue_buswr  = bwr_s2;
	assign issue_data   = bdata_s2;
	assign issue_shared = bshr_s2;
	assign bus_address  = addr_s2;
	assign bus_proc     = proc_s2;
	assign error        = err_s2;

endmodule

[hw/rtl/scc_checker.sv]
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks for the snooping coherence controller, bound to the top.
// ----------------------------------------------------------------------------
module scc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        op,
	input logic [3:0]  current_state,
	input logic        done,
	input logic [3:0]  next_state,
	input logic        perm_avail,
	input logic [1:0]  action,
	input logic        issue_busrd,
	input logic        issue_buswr,
	input logic        issue_data,
	input logic        issue_shared,
	input logic [63:0] bus_address,
	input logic [7:0]  bus_proc,
	input logic        error
);

	// every accepted transaction gives a result through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("result missing two cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##2 !done)
		else $error("result without an accepted transaction");

	// only processor accesses may grant permission
	a_perm_access: assert property (@(posedge clk) disable iff (!arst_n)
		(done && perm_avail) |-> ($past(op, 2) == scc_pkg::OP_ACCESS))
		else $error("permission granted on a snoop");

	a_quiet_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !issue_busrd && !issue_buswr && !issue_data && !issue_shared)
		|-> (bus_address == 64'd0 && bus_proc == 8'd0))
		else $error("bus address or processor driven with no message");

	// an error either drops the line or leaves it where it was
	a_err_state: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (next_state == scc_pkg::ST_I
			|| next_state == $past(current_state, 2)))
		else $error("error with an unexpected next state");

endmodule

bind snoop_coherence_controller_core scc_checker u_scc_checker (.*);

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for snoop_coherence_controller_core. A directed table of
// accesses and snoops covers every scheme, message type and error case. It is
// followed by random per-line state walks under several scheme settings.
// Each result is checked field by field against a typed row or in-bench model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scc_pkg::*;

	// encoding above MESIF, decodes as MI
	localparam logic [2:0] SCH_UNDEF = 3'd7;
	localparam logic [3:0] ST_UNSUP_LO = 4'd10;
	localparam logic [3:0] ST_UNSUP_HI = 4'd15;
	localparam logic [2:0] SEG_SCHEMES [6] = '{SCH_MSI, SCH_MESI, SCH_MI,
		SCH_MOESI, SCH_MESIF, SCH_UNDEF};

	typedef struct packed {
		logic        op;
		logic        is_read;
		bus_req_t    req;
		logic [3:0]  state;
		logic [63:0] addr;
		logic [7:0]  proc;
	} line_txn_t;

	typedef struct packed {
		logic [3:0]  next;
		logic        perm;
		cache_act_t  act;
		logic        rd;
		logic        wr;
		logic        data;
		logic        shr;
		logic [63:0] addr;
		logic [7:0]  proc;
		logic        err;
	} coh_result_t;

	typedef struct {
		logic [2:0]  sch;
		line_txn_t   t;
		logic        typed;
		coh_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic        is_read;
	logic [1:0]  bus_request;
	logic [3:0]  current_state;
	logic [63:0] line_address;
	logic [7:0]  proc_id;
	logic        cfg_we;
	logic [2:0]  cfg_wdata;
	logic        done;
	logic [3:0]  next_state;
	logic        perm_avail;
	logic [1:0]  action;
	logic        issue_busrd;
	logic        issue_buswr;
	logic        issue_data;
	logic        issue_shared;
	logic [63:0] bus_address;
	logic [7:0]  bus_proc;
	logic        error;

	dir_row_t    dir_tbl[$];
	coh_result_t pending_q[$];
	logic [2:0]  line_scheme;
	int          err_count = 0;
	int          result_count = 0;

	snoop_coherence_controller_core dut (
		.clk, .arst_n, .start, .busy, .op, .is_read, .bus_request, .current_state,
		.line_address, .proc_id, .cfg_we, .cfg_wdata, .done, .next_state,
		.perm_avail, .action, .issue_busrd, .issue_buswr, .issue_data,
		.issue_shared, .bus_address, .bus_proc, .error
	);

	always #5 clk = ~clk;

	function automatic coh_result_t predict_line(input logic [2:0] sch, input line_txn_t t);
		coh_result_t r;
		logic mi, excl, owned, fwd, fill, busrd;
		r = '0;
		r.next = ST_I;
		r.act = ACT_NONE;
		mi = (sch == SCH_MI) || (sch > SCH_MESIF);
		excl = (sch == SCH_MESI) || (sch == SCH_MOESI) || (sch == SCH_MESIF);
		owned = (sch == SCH_MOESI);
		fwd = (sch == SCH_MESIF);
		fill = (t.req == REQ_DATA) || (t.req == REQ_SHARED);
		busrd = (t.req == REQ_BUSRD);
		if (mi) begin
			case (t.state)
				ST_I: if (t.op == OP_ACCESS) begin
					r.wr = 1'b1;
					r.next = ST_IM;
				end
				ST_M: if (t.op == OP_ACCESS) begin
					r.perm = 1'b1;
					r.next = ST_M;
				end else begin
					r.data = 1'b1;
					r.act = ACT_INV;
				end
				ST_IM: if (t.op == OP_SNOOP && fill) begin
					r.act = ACT_RECV;
					r.next = ST_M;
				end else begin
					r.next = ST_IM;
				end
				default: r.err = 1'b1;
			endcase
		end else if (t.state > ST_OM) begin
			r.err = 1'b1;
		end else if (t.op == OP_ACCESS) begin
			case (t.state)
				ST_I: if (t.is_read) begin
					r.rd = 1'b1;
					r.next = ST_IS;
				end else begin
					r.wr = 1'b1;
					r.next = ST_IM;
				end
				ST_S, ST_F: if (t.is_read) begin
					r.perm = 1'b1;
					r.next = t.state;
				end else begin
					r.wr = 1'b1;
					r.next = ST_SM;
				end
				ST_E: begin
					r.perm = 1'b1;
					r.next = t.is_read ? ST_E : ST_M;
				end
				ST_M: begin
					r.perm = 1'b1;
					r.next = ST_M;
				end
				ST_O: if (t.is_read) begin
					r.perm = 1'b1;
					r.next = ST_O;
				end else begin
					r.wr = 1'b1;
					r.next = ST_OM;
				end
				default: r.next = t.state;
			endcase
		end else if (fill) begin
			case (t.state)
				ST_IS: begin
					r.act = ACT_RECV;
					if (t.req == REQ_DATA)
						r.next = excl ? ST_E : ST_S;
					else
						r.next = fwd ? ST_F : ST_S;
				end
				ST_IM, ST_SM, ST_OM: begin
					r.act = ACT_RECV;
					r.next = ST_M;
				end
				default: begin
					// fill response with nothing outstanding
					r.next = t.state;
					r.err = 1'b1;
				end
			endcase
		end else begin
			case (t.state)
				ST_I: r.next = ST_I;
				ST_S: if (busrd) begin
					r.shr = 1'b1;
					r.next = ST_S;
				end else begin
					r.act = ACT_INV;
				end
				ST_F: if (busrd) begin
					r.data = 1'b1;
					r.shr = 1'b1;
					r.next = ST_S;
				end else begin
					r.act = ACT_INV;
				end
				ST_E, ST_M, ST_O: begin
					r.data = 1'b1;
					if (busrd) begin
						r.shr = 1'b1;
						if (t.state == ST_E)
							r.next = ST_S;
						else if (t.state == ST_O)
							r.next = ST_O;
						else
							r.next = owned ? ST_O : ST_S;
					end else begin
						r.act = ACT_INV;
					end
				end
				default: r.next = t.state;
			endcase
		end
		if (r.rd || r.wr || r.data || r.shr) begin
			r.addr = t.addr;
			r.proc = t.proc;
		end
		return r;
	endfunction

	function automatic line_txn_t txn(input logic o, input logic rd, input bus_req_t q,
			input logic [3:0] s, input logic [63:0] a, input logic [7:0] p);
		line_txn_t t;
		t.op = o;
		t.is_read = rd;
		t.req = q;
		t.state = s;
		t.addr = a;
		t.proc = p;
		return t;
	endfunction

	function automatic coh_result_t res(input logic [3:0] nx, input logic pm,
			input cache_act_t ac, input logic b_rd, input logic b_wr, input logic b_dat,
			input logic b_shr, input logic [63:0] a, input logic [7:0] p, input logic e);
		coh_result_t r;
		r.next = nx;
		r.perm = pm;
		r.act = ac;
		r.rd = b_rd;
		r.wr = b_wr;
		r.data = b_dat;
		r.shr = b_shr;
		r.addr = a;
		r.proc = p;
		r.err = e;
		return r;
	endfunction

	function automatic void add_row(input logic [2:0] sch, input line_txn_t t,
			input logic typed, input coh_result_t want);
		dir_row_t row;
		row.sch = sch;
		row.t = t;
		row.typed = typed;
		row.want = want;
		dir_tbl.push_back(row);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		err_count++;
		$display("[%0t] MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
			$realtime, result_count, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Handshake sampled at the falling edge: inputs only move at rising edges,
	// so busy here is the value the next rising edge sees.
	task automatic send_txn(input line_txn_t t, input coh_result_t want);
		logic ok;
		start <= 1'b1;
		op <= t.op;
		is_read <= t.is_read;
		bus_request <= t.req;
		current_state <= t.state;
		line_address <= t.addr;
		proc_id <= t.proc;
		ok = 1'b0;
		while (!ok) begin
			@(negedge clk);
			ok = !busy;
			@(posedge clk);
		end
		pending_q.push_back(want);
	endtask

	task automatic rest_cycles(input int n);
		if (n > 0) begin
			start <= 1'b0;
			op <= 1'($urandom);
			is_read <= 1'($urandom);
			bus_request <= 2'($urandom);
			current_state <= 4'($urandom);
			line_address <= {$urandom, $urandom};
			proc_id <= 8'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_pending();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (pending_q.size() != 0 && waited < 100) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_scheme(input logic [2:0] sch);
		drain_pending();
		cfg_we <= 1'b1;
		cfg_wdata <= sch;
		@(posedge clk);
		cfg_we <= 1'b0;
		line_scheme = sch;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		coh_result_t e;
		if (arst_n && done) begin
			result_count++;
			if (pending_q.size() == 0) begin
				report_mismatch("result with no transaction pending", done, 1'b0);
			end else begin
				e = pending_q.pop_front();
				check_field("next_state", next_state, e.next);
				check_field("perm_avail", perm_avail, e.perm);
				check_field("action", action, e.act);
				check_field("issue_busrd", issue_busrd, e.rd);
				check_field("issue_buswr", issue_buswr, e.wr);
				check_field("issue_data", issue_data, e.data);
				check_field("issue_shared", issue_shared, e.shr);
				check_field("bus_address", bus_address, e.addr);
				check_field("bus_proc", bus_proc, e.proc);
				check_field("error", error, e.err);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		line_txn_t   t;
		coh_result_t exp_r;
		logic [3:0]  line_st;
		logic [63:0] cur_addr;
		logic [7:0]  cur_proc;
		int          gap, idle_pct;
		logic [63:0] a1, a2;

		arst_n = 1'b0;
		start = 1'b0;
		op = 1'b0;
		is_read = 1'b0;
		bus_request = REQ_BUSRD;
		current_state = ST_I;
		line_address = '0;
		proc_id = '0;
		cfg_we = 1'b0;
		cfg_wdata = SCH_MI;
		line_scheme = SCH_MI;

		a1 = 64'h0123_4567_89ab_cdef;
		a2 = 64'hfedc_ba98_7654_3210;
		// MI straight out of reset
		add_row(SCH_MI, txn(OP_ACCESS, 1'b0, REQ_BUSRD, ST_I, '1, 8'hff), 1'b1,
			res(ST_IM, 1'b0, ACT_NONE, 1'b0, 1'b1, 1'b0, 1'b0, '1, 8'hff, 1'b0));
		add_row(SCH_MI, txn(OP_ACCESS, 1'b1, REQ_SHARED, ST_M, '0, 8'h00), 1'b1,
			res(ST_M, 1'b1, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b0));
		add_row(SCH_MI, txn(OP_ACCESS, 1'b0, REQ_DATA, ST_IM, a1, 8'h5a), 1'b1,
			res(ST_IM, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b0));
		add_row(SCH_MI, txn(OP_ACCESS, 1'b1, REQ_BUSRD, ST_S, a2, 8'ha5), 1'b1,
			res(ST_I, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		add_row(SCH_MI, txn(OP_SNOOP, 1'b0, REQ_BUSRD, ST_M, a1, 8'h5a), 1'b0, '0);
		add_row(SCH_MI, txn(OP_SNOOP, 1'b1, REQ_DATA, ST_IM, a2, 8'ha5), 1'b0, '0);
		add_row(SCH_MI, txn(OP_SNOOP, 1'b1, REQ_SHARED, ST_UNSUP_HI, '1, 8'hff), 1'b1,
			res(ST_I, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		// undefined scheme encoding
		add_row(SCH_UNDEF, txn(OP_ACCESS, 1'b0, REQ_BUSWR, ST_I, a2, 8'h5a), 1'b0, '0);
		add_row(SCH_UNDEF, txn(OP_SNOOP, 1'b0, REQ_BUSWR, ST_E, a1, 8'ha5), 1'b1,
			res(ST_I, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		add_row(SCH_MSI, txn(OP_ACCESS, 1'b1, REQ_BUSRD, ST_I, a1, 8'h01), 1'b0, '0);
		add_row(SCH_MSI, txn(OP_SNOOP, 1'b0, REQ_DATA, ST_IS, a1, 8'h01), 1'b0, '0);
		add_row(SCH_MSI, txn(OP_ACCESS, 1'b0, REQ_BUSRD, ST_E, a2, 8'h80), 1'b0, '0);
		add_row(SCH_MSI, txn(OP_SNOOP, 1'b1, REQ_BUSRD, ST_S, a2, 8'h80), 1'b0, '0);
		// fill with nothing outstanding
		add_row(SCH_MSI, txn(OP_SNOOP, 1'b0, REQ_DATA, ST_S, a1, 8'h33), 1'b1,
			res(ST_S, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		add_row(SCH_MSI, txn(OP_ACCESS, 1'b1, REQ_BUSWR, ST_UNSUP_LO, a2, 8'h33), 1'b1,
			res(ST_I, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		add_row(SCH_MESI, txn(OP_SNOOP, 1'b1, REQ_DATA, ST_IS, a1, 8'hcc), 1'b0, '0);
		add_row(SCH_MESI, txn(OP_SNOOP, 1'b0, REQ_BUSRD, ST_M, a2, 8'hcc), 1'b0, '0);
		add_row(SCH_MESI, txn(OP_SNOOP, 1'b1, REQ_SHARED, ST_M, a1, 8'h0f), 1'b1,
			res(ST_M, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));
		add_row(SCH_MOESI, txn(OP_SNOOP, 1'b0, REQ_BUSRD, ST_M, a2, 8'hf0), 1'b0, '0);
		add_row(SCH_MOESI, txn(OP_ACCESS, 1'b0, REQ_SHARED, ST_O, a1, 8'hf0), 1'b0, '0);
		add_row(SCH_MOESI, txn(OP_SNOOP, 1'b1, REQ_SHARED, ST_OM, a1, 8'hf0), 1'b0, '0);
		add_row(SCH_MOESI, txn(OP_SNOOP, 1'b0, REQ_BUSWR, ST_O, a2, 8'h7e), 1'b0, '0);
		add_row(SCH_MESIF, txn(OP_SNOOP, 1'b1, REQ_SHARED, ST_IS, a2, 8'h7e), 1'b0, '0);
		add_row(SCH_MESIF, txn(OP_SNOOP, 1'b0, REQ_BUSRD, ST_F, a1, 8'h81), 1'b0, '0);
		add_row(SCH_MESIF, txn(OP_SNOOP, 1'b1, REQ_DATA, ST_UNSUP_HI, '1, 8'hff), 1'b1,
			res(ST_I, 1'b0, ACT_NONE, 1'b0, 1'b0, 1'b0, 1'b0, '0, 8'h00, 1'b1));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[i]) begin
			if (dir_tbl[i].sch != line_scheme)
				set_scheme(dir_tbl[i].sch);
			exp_r = dir_tbl[i].typed ? dir_tbl[i].want : predict_line(line_scheme, dir_tbl[i].t);
			send_txn(dir_tbl[i].t, exp_r);
		end

		// Random walks of one line's state; each scheme change drains the pipe
		line_st = ST_I;
		cur_addr = {$urandom, $urandom};
		cur_proc = 8'($urandom);
		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 36 : (ph == 1) ? 86 : 0;
			for (int seg = 0; seg < 3; seg++) begin
				if (ph * 3 + seg < 6)
					set_scheme(SEG_SCHEMES[ph * 3 + seg]);
				else
					set_scheme(3'($urandom_range(7)));
				for (int n = 0; n < 50; n++) begin
					if ($urandom_range(99) < 5) begin
						line_st = ST_I;
						cur_addr = {$urandom, $urandom};
						cur_proc = 8'($urandom);
					end
					t.op = 1'($urandom_range(1));
					t.is_read = 1'($urandom_range(1));
					t.req = bus_req_t'($urandom_range(3));
					t.state = ($urandom_range(99) < 80) ? line_st : 4'($urandom_range(15));
					t.addr = ($urandom_range(99) < 90) ? cur_addr : {$urandom, $urandom};
					t.proc = ($urandom_range(99) < 90) ? cur_proc : 8'($urandom);
					// pending lines mostly see their fill
					if (t.state >= ST_IS && t.state <= ST_OM && $urandom_range(1)) begin
						t.op = OP_SNOOP;
						t.req = $urandom_range(1) ? REQ_DATA : REQ_SHARED;
					end
					exp_r = predict_line(line_scheme, t);
					gap = 0;
					while ($urandom_range(99) < idle_pct && gap < 40)
						gap++;
					rest_cycles(gap);
					send_txn(t, exp_r);
					line_st = exp_r.next;
				end
			end
		end

		drain_pending();
		if (pending_q.size() != 0)
			report_mismatch("transactions left without result", pending_q.size(), 0);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
